>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/ukst_pkg.sv
// ----------------------------------------------------------------------------
// ukst_pkg
// Constants, codes and types for the unique-key stack.
// ----------------------------------------------------------------------------
package ukst_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int FILL_W = 5;

    localparam logic [1:0] FUNC_PEEK = 2'd0;
    localparam logic [1:0] FUNC_PUSH = 2'd1;
    localparam logic [1:0] FUNC_POP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

>>> rtl/core/ukst_cell.sv
// ----------------------------------------------------------------------------
// ukst_cell
// One stack slot: holds a key/data pair, shifts down on push, up on pop,
// and compares its key against the incoming push key.
// ----------------------------------------------------------------------------
module ukst_cell
    import ukst_pkg::*;
(
    input  logic                     i_clk,
    input  t_shift_ctl               i_ctl,
    input  logic                     i_occupied,
    input  logic signed [KEY_W-1:0]  i_cmp_key,
    input  logic signed [KEY_W-1:0]  i_up_key,
    input  logic signed [DATA_W-1:0] i_up_data,
    input  logic signed [KEY_W-1:0]  i_dn_key,
    input  logic signed [DATA_W-1:0] i_dn_data,
    output logic signed [KEY_W-1:0]  o_key,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_match
);

    logic signed [KEY_W-1:0]  r_key;
    logic signed [DATA_W-1:0] r_data;
    logic signed [KEY_W-1:0]  n_key;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        priority if (i_ctl.push) begin
            n_key  = i_up_key;
            n_data = i_up_data;
        end else if (i_ctl.pop) begin
            n_key  = i_dn_key;
            n_data = i_dn_data;
        end else begin
            n_key  = r_key;
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

    assign o_key   = r_key;
    assign o_data  = r_data;
    assign o_match = i_occupied && (r_key == i_cmp_key);

endmodule

>>> rtl/core/unique_key_stack.sv
// ----------------------------------------------------------------------------
// unique_key_stack
// LIFO of key/data pairs held in a chain of shift cells, top in cell 0.
// Result: registered on the edge that accepts the input transaction.
// Throughput: one transaction per cycle while the result register drains;
//   the single output register sets this figure.
// Reset: clears the fill count and the output valid flag; cell contents
//   stay undefined and are masked by the fill count.
// ----------------------------------------------------------------------------
module unique_key_stack
    import ukst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_func,
    input  logic signed [KEY_W-1:0]  i_push_key,
    input  logic signed [DATA_W-1:0] i_push_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic signed [KEY_W-1:0]  o_out_key,
    output logic signed [DATA_W-1:0] o_out_data,
    output logic                     o_out_valid,
    output logic [FILL_W-1:0]        o_fill_count,
    output logic                     o_is_empty
);

    logic signed [KEY_W-1:0]  w_key  [DEPTH];
    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]         w_match;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                     r_valid;
    logic [1:0]               r_status;
    logic signed [KEY_W-1:0]  r_key;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_out_valid;
    logic [CNT_W-1:0]         r_fill;

    logic                     w_accept;
    logic                     w_dup;
    logic                     w_full;
    logic                     w_empty;
    t_shift_ctl               w_ctl;
    logic [1:0]               w_status;
    logic signed [KEY_W-1:0]  w_res_key;
    logic signed [DATA_W-1:0] w_res_data;
    logic                     w_res_valid;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [KEY_W-1:0]  w_up_key;
            logic signed [DATA_W-1:0] w_up_data;
            logic signed [KEY_W-1:0]  w_dn_key;
            logic signed [DATA_W-1:0] w_dn_data;

            if (gi == 0) begin : g_top
                assign w_up_key  = i_push_key;
                assign w_up_data = i_push_data;
            end else begin : g_mid
                assign w_up_key  = w_key[gi-1];
                assign w_up_data = w_data[gi-1];
            end

            // bottom cell takes nothing from below on pop; slot becomes unused
            if (gi == DEPTH - 1) begin : g_bot
                assign w_dn_key  = '0;
                assign w_dn_data = '0;
            end else begin : g_abv
                assign w_dn_key  = w_key[gi+1];
                assign w_dn_data = w_data[gi+1];
            end

            ukst_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_occupied (r_count > CNT_W'(gi)),
                .i_cmp_key  (i_push_key),
                .i_up_key   (w_up_key),
                .i_up_data  (w_up_data),
                .i_dn_key   (w_dn_key),
                .i_dn_data  (w_dn_data),
                .o_key      (w_key[gi]),
                .o_data     (w_data[gi]),
                .o_match    (w_match[gi])
            );
        end
    endgenerate

    assign w_dup   = |w_match;
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ctl.push  = 1'b0;
        w_ctl.pop   = 1'b0;
        w_status    = ST_OK;
        w_res_key   = '0;
        w_res_data  = '0;
        w_res_valid = 1'b0;
        n_count     = r_count;
        if (!w_empty) begin
            w_res_key   = w_key[0];
            w_res_data  = w_data[0];
            w_res_valid = 1'b1;
        end
        unique case (i_func)
            FUNC_PUSH: begin
                priority if (w_dup) begin
                    w_status = ST_DUP;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.push  = w_accept;
                    n_count     = r_count + CNT_W'(1);
                    w_res_key   = i_push_key;
                    w_res_data  = i_push_data;
                    w_res_valid = 1'b1;
                end
            end
            FUNC_POP: begin
                if (w_empty) begin
                    w_status = ST_UNDER;
                end else begin
                    w_ctl.pop = w_accept;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                // peek, and the unused selector acts as a peek
                if (w_empty) w_status = ST_UNDER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_key       <= w_res_key;
            r_data      <= w_res_data;
            r_out_valid <= w_res_valid;
            r_fill      <= n_count;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_out_key    = r_key;
    assign o_out_data   = r_data;
    assign o_out_valid  = r_out_valid;
    assign o_fill_count = FILL_W'(r_fill);
    assign o_is_empty   = (r_fill == '0);

endmodule

>>> rtl/core/ukst_checker.sv
// ----------------------------------------------------------------------------
// ukst_checker
// Port-level checks on the unique-key stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ukst_checker
    import ukst_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [1:0]               o_status,
    input logic signed [KEY_W-1:0]  o_out_key,
    input logic signed [DATA_W-1:0] o_out_data,
    input logic                     o_out_valid,
    input logic [FILL_W-1:0]        o_fill_count,
    input logic                     o_is_empty
);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    `ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, o_valid, o_is_empty == (o_fill_count == '0))

    `ASSERT_IMP(a_under_no_entry, i_clk, i_rst_n, o_valid && (o_status == ST_UNDER), !o_out_valid && o_is_empty)

    `ASSERT_IMP(a_no_entry_zero, i_clk, i_rst_n, o_valid && !o_out_valid, (o_out_key == '0) && (o_out_data == '0))

    `ASSERT_IMP(a_entry_nonempty, i_clk, i_rst_n, o_valid && o_out_valid && (o_status != ST_OK), !o_is_empty)

endmodule

bind unique_key_stack ukst_checker u_ukst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_out_key    (o_out_key),
    .o_out_data   (o_out_data),
    .o_out_valid  (o_out_valid),
    .o_fill_count (o_fill_count),
    .o_is_empty   (o_is_empty)
);

>>> bench/unique_key_stack_tb.sv
// ----------------------------------------------------------------------------
// unique_key_stack_tb
// Self-checking bench for the unique-key stack. A queue-fed driver offers
// peek, push and pop transactions, a shadow stack predicts each result, and
// a monitor compares every returned field in order. Runs go through phases
// of source gaps and sink stalls, with one long sink hold-off.
// ----------------------------------------------------------------------------
module unique_key_stack_tb;
    import ukst_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused selector, behaves as peek
    localparam int MAX_CYCLES = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 110;

    typedef enum int {PH_FREE, PH_HOLD, PH_SRC_GAP, PH_SNK_STALL, PH_BOTH} t_phase;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] data;
    } t_stack_op;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       key;
        logic [31:0]       data;
        logic              entry_vld;
        logic [FILL_W-1:0] fill;
        logic              empty;
    } t_stack_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_func = FUNC_PEEK;
    logic signed [KEY_W-1:0]  i_push_key = '0;
    logic signed [DATA_W-1:0] i_push_data = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [1:0]               o_status;
    logic signed [KEY_W-1:0]  o_out_key;
    logic signed [DATA_W-1:0] o_out_data;
    logic                     o_out_valid;
    logic [FILL_W-1:0]        o_fill_count;
    logic                     o_is_empty;

    unique_key_stack dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow copy of the stack contents
    logic [31:0] shadow_keys [DEPTH];
    logic [31:0] shadow_data [DEPTH];
    int          shadow_count = 0;

    t_stack_op     op_queue[$];
    t_stack_result due_results[$];

    t_phase cur_phase = PH_FREE;
    int     src_gap_pct = 0;
    int     snk_stall_pct = 0;
    int     hold_cycles = 0;
    int     cycle_count = 0;
    bit     err_seen = 1'b0;

    // random stream shaping
    bit          filling = 1'b1;
    int          run_left = 0;
    logic [31:0] recent_keys [8];
    int          recent_idx = 0;

    function automatic t_stack_result apply_stack_op(logic [1:0] f, logic [31:0] k,
                                                     logic [31:0] d);
        t_stack_result r;
        bit            dup;
        r = '0;
        r.status = ST_OK;
        dup = 1'b0;
        if (f == FUNC_PUSH) begin
            for (int i = 0; i < shadow_count; i++)
                if (shadow_keys[i] == k) dup = 1'b1;
            if (dup) begin
                r.status = ST_DUP;
            end else if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                shadow_keys[shadow_count] = k;
                shadow_data[shadow_count] = d;
                shadow_count++;
            end
        end else if (f == FUNC_POP) begin
            if (shadow_count == 0) begin
                r.status = ST_UNDER;
            end else begin
                shadow_count--;
                r.key = shadow_keys[shadow_count];
                r.data = shadow_data[shadow_count];
                r.entry_vld = 1'b1;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_UNDER;
        end
        // peek, the spare selector and push (refused or not) show the top entry
        if (f != FUNC_POP && shadow_count > 0) begin
            r.key = shadow_keys[shadow_count-1];
            r.data = shadow_data[shadow_count-1];
            r.entry_vld = 1'b1;
        end
        r.fill = shadow_count[FILL_W-1:0];
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    task automatic queue_op(logic [1:0] f, logic [31:0] k, logic [31:0] d);
        op_queue.push_back('{func: f, key: k, data: d});
    endtask

    task automatic queue_random_ops(int n);
        logic [1:0]  f;
        logic [31:0] k;
        int          roll;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                filling = ~filling;
                run_left = $urandom_range(40, 10);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 5)
                f = FUNC_SPARE;
            else if (roll < 15)
                f = FUNC_PEEK;
            else if (roll < 30)
                f = filling ? FUNC_POP : FUNC_PUSH;
            else
                f = filling ? FUNC_PUSH : FUNC_POP;
            // a share of pushes reuse recent keys to provoke duplicates
            if ($urandom_range(99) < 30)
                k = recent_keys[$urandom_range(7)];
            else
                k = $urandom;
            if (f == FUNC_PUSH) begin
                recent_keys[recent_idx] = k;
                recent_idx = (recent_idx + 1) % 8;
            end
            queue_op(f, k, $urandom);
        end
    endtask

    task automatic drain_ops();
        while (op_queue.size() != 0 || i_valid) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_stack_op op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                due_results.push_back(apply_stack_op(i_func, i_push_key, i_push_data));
            if (!i_valid || o_ready) begin
                if (op_queue.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    op = op_queue.pop_front();
                    i_valid <= 1'b1;
                    i_func <= op.func;
                    i_push_key <= op.key;
                    i_push_data <= op.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: random stalls plus one long hold-off in its own count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (cur_phase == PH_HOLD && hold_cycles < HOLD_CYCLES) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            i_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_stack_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $error("result transaction with nothing expected");
                err_seen = 1'b1;
            end else begin
                exp_r = due_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    err_seen = 1'b1;
                end
                if (o_out_key !== exp_r.key) begin
                    $error("out_key: expected %h, got %h", exp_r.key, o_out_key);
                    err_seen = 1'b1;
                end
                if (o_out_data !== exp_r.data) begin
                    $error("out_data: expected %h, got %h", exp_r.data, o_out_data);
                    err_seen = 1'b1;
                end
                if (o_out_valid !== exp_r.entry_vld) begin
                    $error("out_valid: expected %0d, got %0d", exp_r.entry_vld, o_out_valid);
                    err_seen = 1'b1;
                end
                if (o_fill_count !== exp_r.fill) begin
                    $error("fill_count: expected %0d, got %0d", exp_r.fill, o_fill_count);
                    err_seen = 1'b1;
                end
                if (o_is_empty !== exp_r.empty) begin
                    $error("is_empty: expected %0d, got %0d", exp_r.empty, o_is_empty);
                    err_seen = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) recent_keys[i] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack: peek, pop and the spare selector all underflow
        queue_op(FUNC_PEEK, 32'h0, 32'h0);
        queue_op(FUNC_POP, 32'h0, 32'h0);
        queue_op(FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(FUNC_PUSH, 32'h8000_0000, 32'h0);          // duplicate
        queue_op(FUNC_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(FUNC_PUSH, 32'h0, 32'h0);
        queue_op(FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_op(FUNC_PUSH, 32'hAAAA_AAAA, 32'h5555_5555);
        for (int i = 1; i <= 10; i++) queue_op(FUNC_PUSH, i, ~i);
        queue_op(FUNC_PUSH, 32'h1234_5678, 32'hCAFE_0001);  // full, new key
        queue_op(FUNC_PUSH, 32'h0, 32'h1);                  // full and duplicate
        queue_op(FUNC_PEEK, 32'h0, 32'h0);
        queue_op(FUNC_SPARE, 32'h0, 32'h0);
        queue_op(FUNC_POP, 32'h0, 32'h0);
        queue_op(FUNC_PUSH, 32'h1234_5678, 32'hCAFE_0001);
        queue_random_ops(PHASE_ITEMS);
        drain_ops();

        // long sink hold-off while the source keeps offering
        cur_phase = PH_HOLD;
        queue_random_ops(PHASE_ITEMS);
        drain_ops();

        cur_phase = PH_SRC_GAP;
        src_gap_pct = 50;
        queue_random_ops(PHASE_ITEMS);
        drain_ops();

        cur_phase = PH_SNK_STALL;
        src_gap_pct = 0;
        snk_stall_pct = 50;
        queue_random_ops(PHASE_ITEMS);
        drain_ops();

        cur_phase = PH_BOTH;
        src_gap_pct = 19;
        snk_stall_pct = 19;
        queue_random_ops(PHASE_ITEMS);
        drain_ops();

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_seen)
            $display("RESULT: ERROR");
        else
            $display("RESULT: OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ukst_pkg.sv
rtl/core/ukst_cell.sv
rtl/core/unique_key_stack.sv
rtl/core/ukst_checker.sv
bench/unique_key_stack_tb.sv
